### design/frv_pkg.sv
// Shared types and constants for the FASTQ record validator.
// Depends on nothing; every other file of the block imports it.
package frv_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int OUT_BITS    = 32;

    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_NO_FINAL_NL  = 3'd1,
        STATUS_LINE_COUNT   = 3'd2,
        STATUS_MISSING_AT   = 3'd3,
        STATUS_MISSING_PLUS = 3'd4,
        STATUS_EMPTY_ID     = 3'd5,
        STATUS_PLUS_TEXT    = 3'd6,
        STATUS_LEN_MISMATCH = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PHASE_ID   = 2'd0,
        PHASE_SEQ  = 2'd1,
        PHASE_SEP  = 2'd2,
        PHASE_QUAL = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_BITS-1:0]   failing_record;
        logic [OUT_BITS-1:0]   record_count;
    } verdict_t;

    typedef struct packed {
        logic advance;
    } stage_ctl_t;

endpackage

### design/frv_ifs.sv
// Valid/ready channel interfaces for the byte input and the verdict output.
// Depends on frv_pkg.
interface frv_byte_if;
    import frv_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_file;

    modport source (output valid, output byte_value, output byte_present,
                    output end_of_file, input ready);
    modport sink (input valid, input byte_value, input byte_present,
                  input end_of_file, output ready);
endinterface

interface frv_verdict_if;
    import frv_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [OUT_BITS-1:0] failing_record;
    logic [OUT_BITS-1:0] record_count;

    modport source (output valid, output status, output failing_record,
                    output record_count, input ready);
    modport sink (input valid, input status, input failing_record,
                  input record_count, output ready);
endinterface

### design/fastq_record_validator_core.sv
// Top level of the FASTQ record validator: input register, tracking engine, result register.
// Depends on frv_pkg, frv_ifs, frv_in_stage, frv_engine and frv_out_stage.
//
//   channel      | dir | payload                                   | beat
//   byte_in      | in  | byte_value, byte_present, end_of_file     | one file byte or end marker
//   verdict_out  | out | status, failing_record, record_count      | one verdict per file
//
// One byte beat is taken every cycle while byte_in.ready is high; each accepted beat is
// processed from the input register. A verdict passes from there into the result register,
// once that register is free, and is shown on verdict_out.
// Reset clears all tracking state; after each verdict the state returns to its reset values.
// byte_in.ready drops only while an end-of-file beat waits behind a stalled, full result register.
module fastq_record_validator_core (
    input  logic          clk,
    input  logic          rst_n,
    frv_byte_if.sink      byte_in,
    frv_verdict_if.source verdict_out
);
    import frv_pkg::*;

    item_t      item;
    logic       item_valid;
    logic       out_free;
    stage_ctl_t ctl;
    verdict_t   verdict;

    assign ctl.advance = item_valid && (!item.end_of_file || out_free);

    frv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .advance    (ctl.advance),
        .item       (item),
        .item_valid (item_valid)
    );

    frv_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .ctl     (ctl),
        .verdict (verdict)
    );

    frv_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ctl.advance && item.end_of_file),
        .verdict     (verdict),
        .free        (out_free),
        .verdict_out (verdict_out)
    );

endmodule

### design/frv_in_stage.sv
// Input register of the validator: holds one accepted byte beat.
// Depends on frv_pkg and frv_byte_if.
module frv_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    frv_byte_if.sink           byte_in,
    input  logic               advance,
    output frv_pkg::item_t     item,
    output logic               item_valid
);
    import frv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign byte_in.ready = !valid_reg || advance;
    assign take          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next             = 1'b1;
            item_next.byte_value   = byte_in.byte_value;
            item_next.byte_present = byte_in.byte_present;
            item_next.end_of_file  = byte_in.end_of_file;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

### design/frv_engine.sv
// Line and record tracking state of the validator and the verdict logic.
// Depends on frv_pkg.
module frv_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  frv_pkg::item_t      item,
    input  frv_pkg::stage_ctl_t ctl,
    output frv_pkg::verdict_t   verdict
);
    import frv_pkg::*;

    typedef struct packed {
        logic len;
        logic text;
        logic empty;
        logic plus;
        logic at;
    } faults_t;

    localparam int WIDE_BITS = COUNT_BITS + OUT_BITS;

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        len_inc = (&v) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
        cnt_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        logic [WIDE_BITS-1:0] ext;
        ext = WIDE_BITS'(v);
        clip_out = (ext > WIDE_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                        : ext[OUT_BITS-1:0];
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] line_len_reg, line_len_next;
    logic [LENGTH_BITS-1:0] seq_len_reg, seq_len_next;
    faults_t                faults_reg, faults_next;
    status_t                first_code_reg, first_code_next;
    logic [COUNT_BITS-1:0]  first_rec_reg, first_rec_next;
    logic [COUNT_BITS-1:0]  records_reg, records_next;
    logic                   last_nl_reg, last_nl_next;
    logic                   saw_byte_reg, saw_byte_next;
    logic                   is_newline;

    assign is_newline = (item.byte_value == CHAR_NEWLINE);

    always_comb
    begin
        phase_next      = phase_reg;
        line_len_next   = line_len_reg;
        seq_len_next    = seq_len_reg;
        faults_next     = faults_reg;
        first_code_next = first_code_reg;
        first_rec_next  = first_rec_reg;
        records_next    = records_reg;
        last_nl_next    = last_nl_reg;
        saw_byte_next   = saw_byte_reg;
        verdict         = '{status: STATUS_OK, failing_record: '0, record_count: '0};

        if (ctl.advance && item.byte_present)
        begin
            saw_byte_next = 1'b1;
            if (is_newline)
            begin
                unique case (phase_reg)
                    PHASE_ID:
                    begin
                        if (line_len_reg == '0)
                        begin
                            faults_next.at = 1'b1;
                        end
                        if (line_len_reg <= LENGTH_BITS'(1))
                        begin
                            faults_next.empty = 1'b1;
                        end
                    end
                    PHASE_SEQ:
                    begin
                        seq_len_next = line_len_reg;
                    end
                    PHASE_SEP:
                    begin
                        if (line_len_reg == '0)
                        begin
                            faults_next.plus = 1'b1;
                        end
                        if (line_len_reg != LENGTH_BITS'(1))
                        begin
                            faults_next.text = 1'b1;
                        end
                    end
                    PHASE_QUAL:
                    begin
                        if (line_len_reg != seq_len_reg)
                        begin
                            faults_next.len = 1'b1;
                        end
                        if ((faults_next != '0) && (first_code_reg == STATUS_OK))
                        begin
                            if (faults_next.at)
                            begin
                                first_code_next = STATUS_MISSING_AT;
                            end
                            else if (faults_next.plus)
                            begin
                                first_code_next = STATUS_MISSING_PLUS;
                            end
                            else if (faults_next.empty)
                            begin
                                first_code_next = STATUS_EMPTY_ID;
                            end
                            else if (faults_next.text)
                            begin
                                first_code_next = STATUS_PLUS_TEXT;
                            end
                            else
                            begin
                                first_code_next = STATUS_LEN_MISMATCH;
                            end
                            first_rec_next = cnt_inc(records_reg);
                        end
                        records_next = cnt_inc(records_reg);
                        faults_next  = '0;
                    end
                    default:
                    begin
                        faults_next = faults_reg;
                    end
                endcase
                phase_next    = phase_t'(phase_reg + 2'd1);
                line_len_next = '0;
                last_nl_next  = 1'b1;
            end
            else
            begin
                if (line_len_reg == '0)
                begin
                    if ((phase_reg == PHASE_ID) && (item.byte_value != CHAR_AT))
                    begin
                        faults_next.at = 1'b1;
                    end
                    if ((phase_reg == PHASE_SEP) && (item.byte_value != CHAR_PLUS))
                    begin
                        faults_next.plus = 1'b1;
                    end
                end
                line_len_next = len_inc(line_len_reg);
                last_nl_next  = 1'b0;
            end
        end

        if (ctl.advance && item.end_of_file)
        begin
            verdict.record_count = clip_out(records_next);
            if (saw_byte_next && !last_nl_next)
            begin
                verdict.status = STATUS_NO_FINAL_NL;
            end
            else if (phase_next != PHASE_ID)
            begin
                verdict.status = STATUS_LINE_COUNT;
            end
            else
            begin
                verdict.status = first_code_next;
                if (first_code_next != STATUS_OK)
                begin
                    verdict.failing_record = clip_out(first_rec_next);
                end
            end
            phase_next      = PHASE_ID;
            line_len_next   = '0;
            seq_len_next    = '0;
            faults_next     = '0;
            first_code_next = STATUS_OK;
            first_rec_next  = '0;
            records_next    = '0;
            last_nl_next    = 1'b0;
            saw_byte_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_ID;
            line_len_reg   <= '0;
            seq_len_reg    <= '0;
            faults_reg     <= '0;
            first_code_reg <= STATUS_OK;
            first_rec_reg  <= '0;
            records_reg    <= '0;
            last_nl_reg    <= 1'b0;
            saw_byte_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            line_len_reg   <= line_len_next;
            seq_len_reg    <= seq_len_next;
            faults_reg     <= faults_next;
            first_code_reg <= first_code_next;
            first_rec_reg  <= first_rec_next;
            records_reg    <= records_next;
            last_nl_reg    <= last_nl_next;
            saw_byte_reg   <= saw_byte_next;
        end
    end

endmodule

### design/frv_out_stage.sv
// Result register of the validator: holds one verdict beat until taken.
// Depends on frv_pkg and frv_verdict_if.
module frv_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  frv_pkg::verdict_t verdict,
    output logic              free,
    frv_verdict_if.source     verdict_out
);
    import frv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    verdict_t data_reg;
    verdict_t data_next;

    assign free = !valid_reg || verdict_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = verdict;
        end
        else if (verdict_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign verdict_out.valid          = valid_reg;
    assign verdict_out.status         = data_reg.status;
    assign verdict_out.failing_record = data_reg.failing_record;
    assign verdict_out.record_count   = data_reg.record_count;

endmodule

### design/frv_checker.sv
// Port-level checker for the FASTQ record validator, bound to the top level.
// Depends on frv_pkg and fastq_record_validator_core.
module frv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_eof,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [2:0]                   out_status,
    input logic [frv_pkg::OUT_BITS-1:0] out_failing_record,
    input logic [frv_pkg::OUT_BITS-1:0] out_record_count
);
    import frv_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       eof_take;
    logic       out_take;
    logic       record_fault;

    assign eof_take     = in_valid && in_ready && in_eof;
    assign out_take     = out_valid && out_ready;
    assign record_fault = (out_status != STATUS_OK) && (out_status != STATUS_NO_FINAL_NL)
                          && (out_status != STATUS_LINE_COUNT);

    always_comb
    begin
        pending_next = pending_reg + 2'(eof_take) - 2'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A verdict is shown only for an end-of-file beat that has not yet been answered.
    a_verdict_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("verdict without a pending end-of-file beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
                                    && $stable(out_record_count))
        else $error("stalled verdict changed");

    a_no_record_for_file_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_fault |-> (out_failing_record == '0))
        else $error("failing record set for a file-level status");

    a_record_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_fault |-> (out_failing_record != '0)
                                      && (out_failing_record <= out_record_count))
        else $error("failing record outside the counted records");

endmodule

bind fastq_record_validator_core frv_checker u_frv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (byte_in.valid),
    .in_ready           (byte_in.ready),
    .in_eof             (byte_in.end_of_file),
    .out_valid          (verdict_out.valid),
    .out_ready          (verdict_out.ready),
    .out_status         (verdict_out.status),
    .out_failing_record (verdict_out.failing_record),
    .out_record_count   (verdict_out.record_count)
);
